// ===== rtl/spm_pkg.sv =====
`default_nettype none

package spm_pkg;

  // Graph sizing.
  localparam int MAX_VERTICES = 15;
  localparam int WEIGHT_BITS  = 11;
  localparam int NVERT        = MAX_VERTICES + 1;
  localparam int VTX_BITS     = $clog2(NVERT);
  localparam int DIST_BITS    = 15;
  localparam int SUM_BITS     = DIST_BITS + 1;
  localparam int MAT_AW       = 2 * VTX_BITS;
  localparam int MAT_DEPTH    = NVERT * NVERT;

  // Distance that stands for "no path".
  localparam logic [DIST_BITS-1:0] INF_DIST = DIST_BITS'(32767);

  localparam logic [VTX_BITS-1:0] NO_VTX  = '0;
  localparam logic [VTX_BITS-1:0] MAX_VTX = VTX_BITS'(MAX_VERTICES);

  // Configuration register file.
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int VCOUNT_BITS = 4;
  localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = VCOUNT_BITS'(15);
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // What the result register is loaded with.
  typedef enum logic [1:0] {
    EMIT_HOP,
    EMIT_UNREACH,
    EMIT_SAME
  } emit_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EDGE_AB,
    ST_EDGE_BA,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_PATH,
    ST_WALK,
    ST_EMIT_UNR,
    ST_EMIT_SAME
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_req;
    logic       edge_wr_ab;
    logic       edge_wr_ba;
    logic       mat_clear;
    logic       query_init;
    logic       scan_issue;
    logic       scan_commit;
    logic       path_load;
    logic       emit;
    emit_kind_t emit_kind;
  } spm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic edge_ok;
    logic query_ok;
    logic same_vtx;
    logic scan_last;
    logic next_found;
    logic dest_unreach;
    logic hop_last;
    logic out_free;
  } spm_status_t;

endpackage

`default_nettype wire

// ===== rtl/spm_ctrl.sv =====
`default_nettype none

module spm_ctrl
  import spm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire spm_status_t status,
  output spm_cmd_t         cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.emit_kind = EMIT_HOP;
    in_stall      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.op)
          OP_EDGE: begin
            state_nxt = status.edge_ok ? ST_EDGE_AB : ST_IDLE;
          end
          OP_CLEAR: begin
            cmd.mat_clear = 1'b1;
            state_nxt     = ST_IDLE;
          end
          OP_QUERY: begin
            if (!status.query_ok) begin
              state_nxt = ST_EMIT_UNR;
            end else if (status.same_vtx) begin
              state_nxt = ST_EMIT_SAME;
            end else begin
              cmd.query_init = 1'b1;
              state_nxt      = ST_SCAN;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_EDGE_AB: begin
        cmd.edge_wr_ab = 1'b1;
        state_nxt      = ST_EDGE_BA;
      end
      ST_EDGE_BA: begin
        cmd.edge_wr_ba = 1'b1;
        state_nxt      = ST_IDLE;
      end
      // Walk one matrix row, one neighbor per cycle.
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.scan_commit = 1'b1;
        state_nxt       = status.next_found ? ST_SCAN : ST_PATH;
      end
      ST_PATH: begin
        if (status.dest_unreach) begin
          state_nxt = ST_EMIT_UNR;
        end else begin
          cmd.path_load = 1'b1;
          state_nxt     = ST_WALK;
        end
      end
      // Follow predecessors back from the destination.
      ST_WALK: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EMIT_HOP;
          if (status.hop_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT_UNR: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EMIT_UNREACH;
          state_nxt     = ST_IDLE;
        end
      end
      ST_EMIT_SAME: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EMIT_SAME;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/spm_dpath.sv =====
`default_nettype none

module spm_dpath
  import spm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire spm_cmd_t               cmd,
  output spm_status_t                 status,
  input  wire logic [VTX_BITS-1:0]    vtx_count,
  input  wire logic [1:0]             in_cmd,
  input  wire logic [VTX_BITS-1:0]    in_from_vertex,
  input  wire logic [VTX_BITS-1:0]    in_to_vertex,
  input  wire logic [WEIGHT_BITS-1:0] in_edge_weight,
  input  wire logic                   out_stall,
  output logic                        out_valid,
  output logic [VTX_BITS-1:0]         out_hop_vertex,
  output logic [VTX_BITS-1:0]         out_hop_predecessor,
  output logic [DIST_BITS-1:0]        out_total_distance,
  output logic                        out_unreachable,
  output logic                        out_last_hop
);

  // Request registers.
  op_t                    req_op_r;
  logic [VTX_BITS-1:0]    req_a_r;
  logic [VTX_BITS-1:0]    req_b_r;
  logic [WEIGHT_BITS-1:0] req_w_r;

  // Adjacency matrix with per-entry valid bits.
  logic [WEIGHT_BITS-1:0] mat_mem [MAT_DEPTH];
  logic [MAT_DEPTH-1:0]   mat_vld_r;
  logic                   mat_wr_en;
  logic [MAT_AW-1:0]      mat_wr_addr;
  logic [MAT_AW-1:0]      mat_rd_addr;
  logic [WEIGHT_BITS-1:0] mat_rd_data_r;
  logic                   mat_rd_vld_r;

  // Search state.
  logic [VTX_BITS-1:0]    idx_r;
  logic                   proc_vld_r;
  logic [VTX_BITS-1:0]    proc_idx_r;
  logic [VTX_BITS-1:0]    curr_r;
  logic [DIST_BITS-1:0]   curr_dist_r;
  logic [DIST_BITS-1:0]   min_d_r;
  logic [VTX_BITS-1:0]    min_idx_r;
  logic [NVERT-1:0]       visited_r;
  logic [DIST_BITS-1:0]   dist_r [NVERT];
  logic [VTX_BITS-1:0]    pred_r [NVERT];
  logic [VTX_BITS-1:0]    walk_r;
  logic [DIST_BITS-1:0]   total_r;

  // Relaxation step signals.
  logic [VTX_BITS-1:0]    rd_vtx;
  logic [DIST_BITS-1:0]   dist_rd;
  logic [VTX_BITS-1:0]    pred_rd;
  logic [WEIGHT_BITS-1:0] edge_w;
  logic [SUM_BITS-1:0]    sum;
  logic [DIST_BITS-1:0]   sat_sum;
  logic                   vis;
  logic                   relax;
  logic [DIST_BITS-1:0]   new_d;
  logic                   take_min;

  // Result register.
  logic                   out_valid_r;
  logic [VTX_BITS-1:0]    out_vtx_r;
  logic [VTX_BITS-1:0]    out_pred_r;
  logic [DIST_BITS-1:0]   out_dist_r;
  logic                   out_unr_r;
  logic                   out_last_r;
  logic                   out_free;

  // Capture the request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_op_r <= OP_NONE;
    end else if (cmd.load_req) begin
      req_op_r <= op_t'(in_cmd);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_a_r <= in_from_vertex;
      req_b_r <= in_to_vertex;
      req_w_r <= in_edge_weight;
    end
  end

  // Matrix ports: an edge write goes to both halves, a-b in EDGE_AB, then b-a in EDGE_BA.
  assign mat_wr_en   = cmd.edge_wr_ab | cmd.edge_wr_ba;
  assign mat_wr_addr = cmd.edge_wr_ab ? {req_a_r, req_b_r} : {req_b_r, req_a_r};
  assign mat_rd_addr = {curr_r, idx_r};

  always_ff @(posedge clk) begin
    if (mat_wr_en) begin
      mat_mem[mat_wr_addr] <= req_w_r;
    end
  end

  always_ff @(posedge clk) begin
    mat_rd_data_r <= mat_mem[mat_rd_addr];
  end

  // Valid bits make a clear take effect at once.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.mat_clear) begin
      mat_vld_r <= '0;
    end else if (mat_wr_en) begin
      mat_vld_r[mat_wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_rd_vld_r <= 1'b0;
    end else begin
      mat_rd_vld_r <= mat_vld_r[mat_rd_addr];
    end
  end

  // Shared read port of the distance and predecessor files.
  assign rd_vtx  = proc_vld_r ? proc_idx_r : walk_r;
  assign dist_rd = dist_r[rd_vtx];
  assign pred_rd = pred_r[rd_vtx];

  // Relax one neighbor and track the nearest unvisited vertex.
  always_comb begin
    edge_w   = mat_rd_vld_r ? mat_rd_data_r : '0;
    sum      = SUM_BITS'(edge_w) + SUM_BITS'(curr_dist_r);
    sat_sum  = (sum >= SUM_BITS'(INF_DIST)) ? INF_DIST : sum[DIST_BITS-1:0];
    vis      = visited_r[proc_idx_r];
    relax    = (edge_w != '0) && !vis && (dist_rd > sat_sum);
    new_d    = relax ? sat_sum : dist_rd;
    take_min = proc_vld_r && !vis && (new_d < min_d_r);
  end

  // Row scan counter and the processing stage behind the matrix read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_vld_r <= 1'b0;
    end else begin
      proc_vld_r <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_init || cmd.scan_commit) begin
      idx_r <= VTX_BITS'(1);
    end else if (cmd.scan_issue) begin
      idx_r <= idx_r + VTX_BITS'(1);
    end
    if (cmd.scan_issue) begin
      proc_idx_r <= idx_r;
    end
  end

  // Current vertex and running minimum.
  always_ff @(posedge clk) begin
    if (cmd.query_init) begin
      curr_r      <= req_a_r;
      curr_dist_r <= '0;
    end else if (cmd.scan_commit && (min_idx_r != NO_VTX)) begin
      curr_r      <= min_idx_r;
      curr_dist_r <= min_d_r;
    end
    if (cmd.query_init || cmd.scan_commit) begin
      min_d_r   <= INF_DIST;
      min_idx_r <= NO_VTX;
    end else if (take_min) begin
      min_d_r   <= new_d;
      min_idx_r <= proc_idx_r;
    end
  end

  // A new query starts with only the source marked visited.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
    end else if (cmd.query_init) begin
      visited_r <= NVERT'(1) << req_a_r;
    end else if (cmd.scan_commit && (min_idx_r != NO_VTX)) begin
      visited_r[min_idx_r] <= 1'b1;
    end
  end

  // Distance and predecessor files: set up on query_init, then at most one write per relaxed neighbor.
  always_ff @(posedge clk) begin
    if (cmd.query_init) begin
      for (int i = 0; i < NVERT; i++) begin
        dist_r[i] <= (VTX_BITS'(i) == req_a_r) ? '0 : INF_DIST;
        pred_r[i] <= NO_VTX;
      end
    end else if (proc_vld_r && relax) begin
      dist_r[proc_idx_r] <= sat_sum;
      pred_r[proc_idx_r] <= curr_r;
    end
  end

  // Path walk pointer and the distance of the destination.
  always_ff @(posedge clk) begin
    if (cmd.query_init) begin
      walk_r <= req_b_r;
    end else if (cmd.emit && (cmd.emit_kind == EMIT_HOP)) begin
      walk_r <= pred_rd;
    end
    if (cmd.path_load) begin
      total_r <= dist_rd;
    end
  end

  // Result register, refilled while the previous result is taken.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_kind)
        EMIT_HOP: begin
          out_vtx_r  <= walk_r;
          out_pred_r <= pred_rd;
          out_dist_r <= total_r;
          out_unr_r  <= 1'b0;
          out_last_r <= (pred_rd == req_a_r) || (pred_rd == NO_VTX);
        end
        EMIT_SAME: begin
          out_vtx_r  <= req_a_r;
          out_pred_r <= NO_VTX;
          out_dist_r <= '0;
          out_unr_r  <= 1'b0;
          out_last_r <= 1'b1;
        end
        default: begin
          out_vtx_r  <= req_b_r;
          out_pred_r <= NO_VTX;
          out_dist_r <= INF_DIST;
          out_unr_r  <= 1'b1;
          out_last_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hop_vertex      = out_vtx_r;
  assign out_hop_predecessor = out_pred_r;
  assign out_total_distance  = out_dist_r;
  assign out_unreachable     = out_unr_r;
  assign out_last_hop        = out_last_r;

  // Status back to the controller.
  always_comb begin
    status.op           = req_op_r;
    status.edge_ok      = (req_a_r != NO_VTX) && (req_a_r <= MAX_VTX) &&
                          (req_b_r != NO_VTX) && (req_b_r <= MAX_VTX);
    status.query_ok     = (req_a_r != NO_VTX) && (req_a_r <= vtx_count) &&
                          (req_b_r != NO_VTX) && (req_b_r <= vtx_count);
    status.same_vtx     = (req_a_r == req_b_r);
    status.scan_last    = (idx_r == vtx_count);
    status.next_found   = (min_idx_r != NO_VTX);
    status.dest_unreach = (dist_rd >= INF_DIST);
    status.hop_last     = (pred_rd == req_a_r) || (pred_rd == NO_VTX);
    status.out_free     = out_free;
  end

endmodule

`default_nettype wire

// ===== rtl/shortest_path_matrix.sv =====
// Shortest path engine over a small undirected weighted graph.
// Input channel (in_valid / in_stall): each request carries a command. An edge
// write stores one weight in both directions, a clear empties the matrix at
// once, and a query runs Dijkstra from in_from_vertex. After its setup, a
// query scans one matrix row per visited vertex, one neighbor per cycle from
// the single matrix read port, and then emits its hops. Only one request is
// in progress at a time; in_stall is high after acceptance until the request
// is done, for a query until its last result has been loaded.
// Result channel (out_valid / out_stall): one result per hop from the
// destination back to the source, last_hop set on the final one; a query that
// cannot be served gives one result flagged unreachable. A one-entry result
// register lets a new request be accepted while the last result waits. While
// out_stall is high the result is held and the path walk pauses.
// Configuration: register vertex_count at byte address 0, user writes it only
// while idle, which the block does not enforce. Reset (rst_n low, synchronous)
// empties the matrix, sets vertex_count to 15 and drops any pending result.
`default_nettype none

module shortest_path_matrix
  import spm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_cmd,
  input  wire logic [VTX_BITS-1:0]    in_from_vertex,
  input  wire logic [VTX_BITS-1:0]    in_to_vertex,
  input  wire logic [WEIGHT_BITS-1:0] in_edge_weight,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [VTX_BITS-1:0]         out_hop_vertex,
  output logic [VTX_BITS-1:0]         out_hop_predecessor,
  output logic [DIST_BITS-1:0]        out_total_distance,
  output logic                        out_unreachable,
  output logic                        out_last_hop,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_AW-1:0]      cfg_paddr,
  input  wire logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]           cfg_prdata,
  output logic                        cfg_pready
);

  logic [VCOUNT_BITS-1:0] vcount_r;
  logic [VTX_BITS-1:0]    vtx_count;
  logic                   cfg_sel_vc;
  spm_cmd_t               cmd;
  spm_status_t            status;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_sel_vc = (cfg_paddr[CFG_AW-1] == REG_VERTEX_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_vc) begin
      vcount_r <= cfg_pwdata[VCOUNT_BITS-1:0];
    end
  end

  assign cfg_prdata = cfg_sel_vc ? CFG_DW'(vcount_r) : '0;

  // Effective vertex count: zero acts as one, clamped to the matrix size.
  always_comb begin
    if (vcount_r == '0) begin
      vtx_count = VTX_BITS'(1);
    end else if (VTX_BITS'(vcount_r) > MAX_VTX) begin
      vtx_count = MAX_VTX;
    end else begin
      vtx_count = VTX_BITS'(vcount_r);
    end
  end

  spm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  spm_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .vtx_count           (vtx_count),
    .in_cmd              (in_cmd),
    .in_from_vertex      (in_from_vertex),
    .in_to_vertex        (in_to_vertex),
    .in_edge_weight      (in_edge_weight),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_hop_vertex      (out_hop_vertex),
    .out_hop_predecessor (out_hop_predecessor),
    .out_total_distance  (out_total_distance),
    .out_unreachable     (out_unreachable),
    .out_last_hop        (out_last_hop)
  );

  // An accepted request always makes the block busy on the next cycle.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepting a request");

  // An unreachable result is always final and carries the infinite distance.
  a_unreach_form : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unreachable |-> out_last_hop && (out_total_distance == INF_DIST))
    else $error("malformed unreachable result");

  // Any hop that is not the last one has a real predecessor.
  a_mid_hop_pred : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_hop |-> (out_hop_predecessor != NO_VTX) && !out_unreachable)
    else $error("intermediate hop without predecessor");

endmodule

`default_nettype wire
